FILE: rtl/core/ldfd_pkg.sv
// Shared types, constants and helper functions for the laser distance frame decoder.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none
package ldfd_pkg;

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned DIST_W  = 21;
  localparam int unsigned RANGE_W = 10;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned PART_W  = 6;
  localparam int unsigned PROD_W  = RAW_W + RANGE_W;
  localparam int unsigned DQ_W    = 32;
  localparam int unsigned MQ_W    = 2 * DQ_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // 1020/65520 reduces to 17/1092. The division by 1092 is a multiplication by
  // ceil(2^42/1092) followed by a shift of 42, which is exact below 2^31.
  localparam logic [RAW_W-1:0]   ERR_CODE = 16'd65467;
  localparam logic [RAW_W-1:0]   MID_CODE = 16'(65467 / 2);
  localparam int unsigned        RECIP_SHIFT = 42;
  localparam logic [DQ_W-1:0]    RECIP_M  = 32'd4027515121;
  localparam logic [LIMIT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [RANGE_W-1:0]       RANGE_RST = 10'd50;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST = 16'd100;
  localparam logic signed [DIST_W-1:0] FAR_RST   = 21'sd50500;
  localparam logic signed [DIST_W-1:0] NEAR_RST  = -21'sd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE     = 2'd0,
    CFG_BAD_LIMIT = 2'd1,
    CFG_FAR       = 2'd2,
    CFG_NEAR      = 2'd3
  } ldfd_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_TOLER   = 2'd1,
    ST_PERSIST = 2'd2
  } ldfd_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_LOAD,
    B_RECIP,
    B_WRITE
  } ldfd_bstate_t;

  typedef struct packed {
    logic [RANGE_W-1:0]       range_mm;
    logic [LIMIT_W-1:0]       bad_limit;
    logic signed [DIST_W-1:0] far_error_um;
    logic signed [DIST_W-1:0] near_error_um;
  } ldfd_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ldfd_qstat_t;

endpackage
`default_nettype wire

FILE: rtl/core/ldfd_queue.sv
// Short queue of assembled raw values between the byte front end and the back end.
// Depends on ldfd_pkg.
`default_nettype none
module ldfd_queue (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [ldfd_pkg::RAW_W-1:0]   wdata,
  input  wire logic                         pop,
  output logic [ldfd_pkg::RAW_W-1:0]        rdata,
  output ldfd_pkg::ldfd_qstat_t             stat
);

  logic [ldfd_pkg::RAW_W-1:0]  ent_r [ldfd_pkg::QDEPTH];
  logic [ldfd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ldfd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ldfd_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == ldfd_pkg::QCNT_W'(ldfd_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ldfd_pkg::QPTR_W'(ldfd_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ldfd_pkg::QPTR_W'(ldfd_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ldfd_front.sv
// Byte front end: sorts received bytes into frame parts and emits a raw value per frame.
// Depends on ldfd_pkg; feeds ldfd_queue.
`default_nettype none
module ldfd_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_rx_byte,
  input  wire ldfd_pkg::ldfd_qstat_t        q_stat,
  output logic                              q_push,
  output logic [ldfd_pkg::RAW_W-1:0]        q_wdata
);

  logic [ldfd_pkg::PART_W-1:0] low_r, low_nxt;
  logic [ldfd_pkg::PART_W-1:0] mid_r, mid_nxt;
  logic                        take;

  assign in_stall = q_stat.full;
  assign take     = in_valid && !q_stat.full;
  assign q_push   = take && in_rx_byte[7];
  assign q_wdata  = {in_rx_byte[3:0], mid_r, low_r};

  always_comb begin
    low_nxt = low_r;
    mid_nxt = mid_r;
    if (take && !in_rx_byte[7]) begin
      if (in_rx_byte[6]) begin
        mid_nxt = in_rx_byte[5:0];
      end else begin
        low_nxt = in_rx_byte[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= '0;
      mid_r <= '0;
    end else begin
      low_r <= low_nxt;
      mid_r <= mid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ldfd_back.sv
// Back end: converts queued raw values to distances and tracks bad samples.
// Uses registered multipliers and a reciprocal multiplication; depends on ldfd_pkg.
`default_nettype none
module ldfd_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire ldfd_pkg::ldfd_cfg_t                cfg,
  input  wire ldfd_pkg::ldfd_qstat_t              q_stat,
  input  wire logic [ldfd_pkg::RAW_W-1:0]         q_rdata,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [ldfd_pkg::DIST_W-1:0]      out_distance_um,
  output logic [ldfd_pkg::RAW_W-1:0]              out_raw_value,
  output logic [1:0]                              out_status
);

  ldfd_pkg::ldfd_bstate_t state_r, state_nxt;

  logic [ldfd_pkg::RAW_W-1:0]     raw_r;
  logic [ldfd_pkg::PROD_W-1:0]    prod_r;
  logic [ldfd_pkg::DQ_W-1:0]      dq_r;
  logic [ldfd_pkg::MQ_W-1:0]      mq_r;

  logic [ldfd_pkg::LIMIT_W-1:0]     bad_count_r, bad_count_nxt;
  logic [ldfd_pkg::RAW_W-1:0]       last_good_r, last_good_nxt;
  logic signed [ldfd_pkg::DIST_W-1:0] held_r, held_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [ldfd_pkg::DIST_W-1:0] out_dist_r;
  logic [ldfd_pkg::RAW_W-1:0]         out_raw_r;
  ldfd_pkg::ldfd_status_t             out_status_r;

  logic                               fire;
  logic                               is_err;
  logic [ldfd_pkg::DIST_W-1:0]        offset;
  logic [ldfd_pkg::DIST_W-1:0]        quot;
  logic signed [ldfd_pkg::DIST_W-1:0] res_dist;
  ldfd_pkg::ldfd_status_t             res_status;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ldfd_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (q_rdata == ldfd_pkg::ERR_CODE) ? ldfd_pkg::B_WRITE : ldfd_pkg::B_MUL;
        end
      end
      ldfd_pkg::B_MUL:   state_nxt = ldfd_pkg::B_LOAD;
      ldfd_pkg::B_LOAD:  state_nxt = ldfd_pkg::B_RECIP;
      ldfd_pkg::B_RECIP: state_nxt = ldfd_pkg::B_WRITE;
      ldfd_pkg::B_WRITE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ldfd_pkg::B_IDLE;
        end
      end
      default: state_nxt = ldfd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    fire  = 1'b0;
    case (state_r)
      ldfd_pkg::B_IDLE:  q_pop = !q_stat.empty;
      ldfd_pkg::B_WRITE: fire  = !out_valid_r || !out_stall;
      default: begin
        q_pop = 1'b0;
        fire  = 1'b0;
      end
    endcase
  end

  assign quot   = mq_r[ldfd_pkg::RECIP_SHIFT +: ldfd_pkg::DIST_W];
  assign is_err = (raw_r == ldfd_pkg::ERR_CODE);
  assign offset = (ldfd_pkg::DIST_W'(cfg.range_mm) << 3) +
                  (ldfd_pkg::DIST_W'(cfg.range_mm) << 1);

  always_comb begin
    bad_count_nxt = bad_count_r;
    last_good_nxt = last_good_r;
    held_nxt      = held_r;
    res_dist      = held_r;
    res_status    = ldfd_pkg::ST_TOLER;
    if (is_err) begin
      if (bad_count_r > cfg.bad_limit) begin
        res_dist   = (last_good_r > ldfd_pkg::MID_CODE) ? cfg.far_error_um :
                     cfg.near_error_um;
        res_status = ldfd_pkg::ST_PERSIST;
        held_nxt   = res_dist;
      end else begin
        if (bad_count_r != ldfd_pkg::COUNT_MAX) begin
          bad_count_nxt = bad_count_r + 1'b1;
        end
      end
    end else begin
      res_dist      = $signed(quot - offset);
      res_status    = ldfd_pkg::ST_GOOD;
      held_nxt      = res_dist;
      last_good_nxt = raw_r;
      bad_count_nxt = '0;
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ldfd_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      bad_count_r <= '0;
      last_good_r <= '0;
      held_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        bad_count_r <= bad_count_nxt;
        last_good_r <= last_good_nxt;
        held_r      <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      raw_r <= q_rdata;
    end
    if (state_r == ldfd_pkg::B_MUL) begin
      prod_r <= ldfd_pkg::PROD_W'(raw_r) * ldfd_pkg::PROD_W'(cfg.range_mm);
    end
    if (state_r == ldfd_pkg::B_LOAD) begin
      dq_r <= (ldfd_pkg::DQ_W'(prod_r) << 4) + ldfd_pkg::DQ_W'(prod_r);
    end
    if (state_r == ldfd_pkg::B_RECIP) begin
      mq_r <= ldfd_pkg::MQ_W'(dq_r) * ldfd_pkg::MQ_W'(ldfd_pkg::RECIP_M);
    end
    if (fire) begin
      out_dist_r   <= res_dist;
      out_raw_r    <= raw_r;
      out_status_r <= res_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_distance_um = out_dist_r;
  assign out_raw_value   = out_raw_r;
  assign out_status      = out_status_r;

endmodule
`default_nettype wire

FILE: rtl/core/laser_distance_frame_decoder.sv
// Top level of the laser distance frame decoder: configuration registers and wiring.
// Instantiates ldfd_front, ldfd_queue and ldfd_back; depends on ldfd_pkg.
//
// Usage: received sensor bytes enter on in_valid/in_stall/in_rx_byte. Low and middle
// bytes only update the frame parts; each high byte completes a frame and gives exactly
// one result on out_valid/out_stall with distance, raw value and status.
// A byte is taken whenever the two-entry frame queue has room.
// For a good sample the high byte transfer is followed by a pop, a multiply, a scale
// by 17, a reciprocal multiply and a write, in that order, and the write gives the result.
// An error-code sample goes from the pop straight to the write. The back end handles
// one frame at a time, so it pops the next frame only once the last one is written.
// When the receiver stalls, the result holds in the output register, the back end
// finishes its next frame and waits, and in_stall rises once the queue fills.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata.
// Synchronous active-low reset restores the register defaults, clears the frame
// parts, bad-sample count, last good value and held distance, and empties the queue.
`default_nettype none
module laser_distance_frame_decoder (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [7:0]                            in_rx_byte,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [ldfd_pkg::DIST_W-1:0]         out_distance_um,
  output logic [ldfd_pkg::RAW_W-1:0]                 out_raw_value,
  output logic [1:0]                                 out_status,
  input  wire logic                                  cfg_we,
  input  wire logic [ldfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [ldfd_pkg::DIST_W-1:0]           cfg_wdata
);

  ldfd_pkg::ldfd_cfg_t   cfg_r, cfg_nxt;
  ldfd_pkg::ldfd_qstat_t q_stat;
  logic                  q_push;
  logic                  q_pop;
  logic [ldfd_pkg::RAW_W-1:0] q_wdata;
  logic [ldfd_pkg::RAW_W-1:0] q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (ldfd_pkg::ldfd_cfg_idx_t'(cfg_index))
        ldfd_pkg::CFG_RANGE:     cfg_nxt.range_mm      = cfg_wdata[ldfd_pkg::RANGE_W-1:0];
        ldfd_pkg::CFG_BAD_LIMIT: cfg_nxt.bad_limit     = cfg_wdata[ldfd_pkg::LIMIT_W-1:0];
        ldfd_pkg::CFG_FAR:       cfg_nxt.far_error_um  = $signed(cfg_wdata);
        ldfd_pkg::CFG_NEAR:      cfg_nxt.near_error_um = $signed(cfg_wdata);
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_mm      <= ldfd_pkg::RANGE_RST;
      cfg_r.bad_limit     <= ldfd_pkg::LIMIT_RST;
      cfg_r.far_error_um  <= ldfd_pkg::FAR_RST;
      cfg_r.near_error_um <= ldfd_pkg::NEAR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ldfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  ldfd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  ldfd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_stat          (q_stat),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_distance_um (out_distance_um),
    .out_raw_value   (out_raw_value),
    .out_status      (out_status)
  );

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("frame queue popped while empty");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("result carries an undefined status code");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid directly after reset");
`endif

endmodule
`default_nettype wire
